/* rtl/lpcc_pkg.sv */
// shared types and constants of the label pair co-occurrence counter
package lpcc_pkg;

    // fixed widths of the result fields
    localparam int OUT_COUNT_BITS = 32;
    localparam int DISTINCT_BITS  = 16;
    localparam int OUT_DATA_BITS  = ((OUT_COUNT_BITS + DISTINCT_BITS + 1 + 7) / 8) * 8;

    // commands carried in the slave tuser bit
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic clr_en;    // write one zero entry of the clearing sweep
        logic rd_en;     // capture the input transaction and read its bin
        logic upd_en;    // update the bin and stage the result
        logic out_load;  // move the staged result into the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;     // last entry of the sweep is being written
        logic need_result;  // current item produces a result
        logic out_free;     // output register can take a result this cycle
    } t_dp_stat;

endpackage

/* rtl/lpcc_ctrl.sv */
// controller state machine: clearing sweep, accept, update, result hand-off
module lpcc_ctrl
    import lpcc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_s_tready     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.rd_en = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.upd_en = 1'b1;
                n_state      = i_stat.need_result ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                o_cmd.out_load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/lpcc_datapath.sv */
// datapath: bin memory, distinct pair count, result staging and output register
module lpcc_datapath
    import lpcc_pkg::*;
#(
    parameter int LABEL_BITS = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_command,
    input  logic [LABEL_BITS-1:0]     i_label_a,
    input  logic [LABEL_BITS-1:0]     i_label_b,
    input  logic                      i_last_pair,
    input  logic                      i_m_tready,
    output logic                      o_m_tvalid,
    output logic [OUT_COUNT_BITS-1:0] o_pair_count,
    output logic [DISTINCT_BITS-1:0]  o_distinct_pairs,
    output logic                      o_count_saturated,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat
);

    localparam int ADDR_BITS = 2 * LABEL_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;

    // bin memory
    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;

    // captured item
    logic                 r_cmd;
    logic                 r_last;
    logic                 r_hit;
    logic [ADDR_BITS-1:0] r_addr;

    // clearing sweep pointer
    logic [ADDR_BITS-1:0] r_clr_ptr;

    // distinct pair count
    logic [DISTINCT_BITS-1:0] r_distinct;
    logic [DISTINCT_BITS-1:0] n_distinct;

    // staged result
    logic [OUT_COUNT_BITS-1:0] r_res_count;
    logic [DISTINCT_BITS-1:0]  r_res_dist;
    logic                      r_res_sat;

    // output register
    logic                      r_out_valid;
    logic [OUT_COUNT_BITS-1:0] r_out_count;
    logic [DISTINCT_BITS-1:0]  r_out_dist;
    logic                      r_out_sat;

    logic                      w_full;
    logic                      w_bump;
    logic                      w_we;
    logic [ADDR_BITS-1:0]      w_wa;
    logic [COUNT_BITS-1:0]     w_wd;
    logic [OUT_COUNT_BITS-1:0] w_cnt_low;

    assign w_full = (r_rd_data == {COUNT_BITS{1'b1}});
    assign w_bump = r_hit && (r_cmd == CMD_ACCUMULATE);

    // low bits of the bin, or the bin zero-extended, as shown on the result
    generate
        if (COUNT_BITS >= OUT_COUNT_BITS) begin : g_cnt_trunc
            assign w_cnt_low = r_rd_data[OUT_COUNT_BITS-1:0];
        end else begin : g_cnt_ext
            assign w_cnt_low = {{(OUT_COUNT_BITS-COUNT_BITS){1'b0}}, r_rd_data};
        end
    endgenerate

    // memory write port: sweep zeros, or a saturating increment
    assign w_we = i_cmd.clr_en || (i_cmd.upd_en && w_bump && !w_full);
    assign w_wa = i_cmd.clr_en ? r_clr_ptr : r_addr;
    assign w_wd = i_cmd.clr_en ? '0 : COUNT_BITS'(r_rd_data + 1'b1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[{i_label_a, i_label_b}];
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_cmd  <= i_command;
            r_last <= i_last_pair;
            r_hit  <= (i_label_a != '0) && (i_label_b != '0);
            r_addr <= {i_label_a, i_label_b};
        end
    end

    // clearing sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_ptr <= r_clr_ptr + 1'b1;
        end
    end

    // distinct count bumps on a bin leaving zero, saturating
    always_comb begin
        n_distinct = r_distinct;
        if (w_bump && (r_rd_data == '0) && (r_distinct != {DISTINCT_BITS{1'b1}})) begin
            n_distinct = r_distinct + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distinct <= '0;
        end else if (i_cmd.upd_en) begin
            r_distinct <= n_distinct;
        end
    end

    // result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_en) begin
            r_res_dist <= n_distinct;
            if (r_cmd == CMD_READ) begin
                r_res_count <= w_cnt_low;
                r_res_sat   <= w_full;
            end else begin
                r_res_count <= '0;
                r_res_sat   <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= r_res_count;
            r_out_dist  <= r_res_dist;
            r_out_sat   <= r_res_sat;
        end
    end

    assign o_m_tvalid        = r_out_valid;
    assign o_pair_count      = r_out_count;
    assign o_distinct_pairs  = r_out_dist;
    assign o_count_saturated = r_out_sat;

    // status back to the controller
    assign o_stat.clr_done    = (r_clr_ptr == {ADDR_BITS{1'b1}});
    assign o_stat.need_result = (r_cmd == CMD_READ) || r_last;
    assign o_stat.out_free    = !r_out_valid || i_m_tready;

endmodule

/* rtl/label_pair_cooccurrence_counter.sv */
// top level of the label pair co-occurrence counter
//
// Joint histogram of two label images: each accumulate transaction bumps the bin
// of its (label_a, label_b) pair when both labels are nonzero, saturating, and a
// bin leaving zero raises the distinct pair count; an accumulate with tlast
// reports that count, a read returns one bin and the count. After reset the bin
// memory of 2^(2*LABEL_BITS) entries (65536 at the default) is swept to zero,
// one entry per cycle, with s_tready low throughout. Afterwards each item goes
// through the registered memory read and the increment written back, and one
// that produces a result then hands the staged result to the output register
// once it is free. The output register lets the next item be accepted while a
// result waits on m_tready.
module label_pair_cooccurrence_counter
    import lpcc_pkg::*;
#(
    parameter int LABEL_BITS = 8,
    parameter int COUNT_BITS = 32,
    parameter int IN_DATA_BITS = ((2 * LABEL_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,   // label_a, label_b, zero fill
    input  logic                     i_s_tuser,   // command
    input  logic                     i_s_tlast,   // last_pair
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata    // pair_count, distinct_pairs,
                                                  // count_saturated, zero fill
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    logic [OUT_COUNT_BITS-1:0] w_pair_count;
    logic [DISTINCT_BITS-1:0]  w_distinct;
    logic                      w_sat;

    lpcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lpcc_datapath #(
        .LABEL_BITS (LABEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_command         (i_s_tuser),
        .i_label_a         (i_s_tdata[LABEL_BITS-1:0]),
        .i_label_b         (i_s_tdata[2*LABEL_BITS-1:LABEL_BITS]),
        .i_last_pair       (i_s_tlast),
        .i_m_tready        (i_m_tready),
        .o_m_tvalid        (o_m_tvalid),
        .o_pair_count      (w_pair_count),
        .o_distinct_pairs  (w_distinct),
        .o_count_saturated (w_sat),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat)
    );

    // result packing, lowest field first
    assign o_m_tdata = {{(OUT_DATA_BITS-OUT_COUNT_BITS-DISTINCT_BITS-1){1'b0}},
                        w_sat, w_distinct, w_pair_count};

endmodule

/* rtl/lpcc_checker.sv */
// port-level checker of the label pair co-occurrence counter and its bind
module lpcc_checker
    import lpcc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_tvalid,
    input logic                     o_s_tready,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [OUT_DATA_BITS-1:0] o_m_tdata
);

    // a held result keeps its data until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one item at a time: an accepted transaction blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    // reset empties the output and holds off input, as seen right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("output or input active right after reset");

    // a new result only shows up as an item in work finishes
    a_no_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(o_m_tvalid) && o_m_tvalid && o_s_tready |-> $past(!o_s_tready))
        else $error("result appeared without an item in work");

endmodule

bind label_pair_cooccurrence_counter lpcc_checker u_lpcc_checker (.*);
